>>> hdl/rsi_pkg.sv
// Shared types and constants for the ray and unit sphere intersection block
package rsi_pkg;

	localparam int NUM_REGS = 8;
	localparam int REG_WIDTH = 64;
	localparam int ADDR_WIDTH = 6;
	localparam int HALF_WIDTH = 32;

	typedef enum logic [2:0] {
		REG_M00_M01 = 3'd0,
		REG_M02_M03 = 3'd1,
		REG_M10_M11 = 3'd2,
		REG_M12_M13 = 3'd3,
		REG_M20_M21 = 3'd4,
		REG_M22_M23 = 3'd5,
		REG_M30_M31 = 3'd6,
		REG_M32_M33 = 3'd7
	} reg_idx_t;

	localparam logic [REG_WIDTH-1:0] RESET_DIAG_LO = 64'h0000_0000_0001_0000;
	localparam logic [REG_WIDTH-1:0] RESET_DIAG_HI = 64'h0001_0000_0000_0000;

	typedef logic signed [HALF_WIDTH-1:0] entry_t;

	typedef struct packed {
		entry_t m0;
		entry_t m1;
		entry_t m2;
		entry_t m3;
	} mat_row_t;

endpackage

>>> hdl/ray_sphere_intersect.sv
// Top level of the ray and unit sphere intersection pipeline
// Use: rays enter on the s_axis channel (tdata holds origin x,y,z then
// direction x,y,z, signed Q16.16). Each ray is mapped into object space by
// the inverse transform held in eight 64 bit APB registers (reset: identity)
// and solved against the unit sphere. A hit gives two items on m_axis:
// the near distance, then the far one with tlast set; a miss or a zero
// direction gives none. Results saturate to signed Q16.16.
// The pipeline is one long chain of registered stages with valid bits; an
// accepted ray passes seven arithmetic stages, 64 square root stages, one
// numerator stage, 81 divider stages and the output buffer before its near
// item can be taken, and the far item follows it. A ray may enter every
// cycle while the pipe advances; each hit puts two items on the output. A
// four entry skid stage at the end lets the pipe run while the receiver
// stalls; s_axis_tready falls while a pair waits at the end of the pipe and
// the skid stage holds more than two items, and the whole pipe then holds,
// losing and repeating nothing.
// Reset clears all valid bits and loads the identity matrix.
module ray_sphere_intersect #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rsi_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [6*COORD_WIDTH-1:0]      s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// hit_distance
	output logic [COORD_WIDTH-1:0]        m_axis_tdata,
	output logic                          m_axis_tlast
);
	import rsi_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int PW = 2 * CW;
	localparam int NW = 2 * PW;
	localparam int MW = HALF_WIDTH + CW;

	logic [REG_WIDTH-1:0] regs_q [0:NUM_REGS-1];
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_M00_M01] <= RESET_DIAG_LO;
			regs_q[REG_M02_M03] <= '0;
			regs_q[REG_M10_M11] <= RESET_DIAG_HI;
			regs_q[REG_M12_M13] <= '0;
			regs_q[REG_M20_M21] <= '0;
			regs_q[REG_M22_M23] <= RESET_DIAG_LO;
			regs_q[REG_M30_M31] <= '0;
			regs_q[REG_M32_M33] <= RESET_DIAG_HI;
		end else if (wr_en && paddr[2:0] == 3'd0) begin
			regs_q[paddr[5:3]] <= pwdata;
		end
	end

	assign prdata = (paddr[2:0] == 3'd0) ? regs_q[paddr[5:3]] : '0;

	mat_row_t row [0:2];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row[r].m0 = regs_q[2*r][31:0];
			row[r].m1 = regs_q[2*r][63:32];
			row[r].m2 = regs_q[2*r+1][31:0];
			row[r].m3 = regs_q[2*r+1][63:32];
		end
	end

	// Pipeline enable: the skid stage holds up to four items
	logic en;
	logic [2:0] fifo_cnt_q;
	localparam int DEPTH = 4;
	logic out_v; // item pair leaving the pipe this cycle
	// Conservative: advance when the buffer can take two more items or no pair is leaving
	assign en = (fifo_cnt_q <= 3'(DEPTH - 2)) || !out_v;
	assign s_axis_tready = en;

	logic in_fire;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// Stage 1: products m*v
	logic signed [CW-1:0] vin [0:5];
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			vin[k] = s_axis_tdata[k*CW +: CW];
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [MW-1:0] po_s1 [0:2][0:2];
	logic signed [MW-1:0] pd_s1 [0:2][0:2];
	logic signed [HALF_WIDTH-1:0] t_s1 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				po_s1[r][0] <= MW'(row[r].m0) * MW'(vin[0]);
				po_s1[r][1] <= MW'(row[r].m1) * MW'(vin[1]);
				po_s1[r][2] <= MW'(row[r].m2) * MW'(vin[2]);
				pd_s1[r][0] <= MW'(row[r].m0) * MW'(vin[3]);
				pd_s1[r][1] <= MW'(row[r].m1) * MW'(vin[4]);
				pd_s1[r][2] <= MW'(row[r].m2) * MW'(vin[5]);
				t_s1[r] <= row[r].m3;
			end
		end
	end

	// Stage 2: floor-shifted sums, saturation to +-(2^(CW-1)-1)
	localparam int SW = MW + 3;
	localparam logic signed [SW-1:0] LIM = SW'((65'd1 << (CW - 1)) - 65'd1);
	logic signed [CW-1:0] o_s2 [0:2];
	logic signed [CW-1:0] d_s2 [0:2];

	function automatic logic signed [CW-1:0] sat_c(input logic signed [SW-1:0] x);
		if (x > LIM) begin
			return CW'(LIM);
		end
		if (x < -LIM) begin
			return CW'(-LIM);
		end
		return CW'(x);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				o_s2[r] <= sat_c(SW'(t_s1[r]) + SW'(po_s1[r][0] >>> FRAC_BITS)
					+ SW'(po_s1[r][1] >>> FRAC_BITS) + SW'(po_s1[r][2] >>> FRAC_BITS));
				d_s2[r] <= sat_c(SW'(pd_s1[r][0] >>> FRAC_BITS)
					+ SW'(pd_s1[r][1] >>> FRAC_BITS) + SW'(pd_s1[r][2] >>> FRAC_BITS));
			end
		end
	end

	// Stage 3: magnitude products
	logic [PW-1:0] dd_s3 [0:2];
	logic [PW-1:0] oo_s3 [0:2];
	logic [PW-1:0] dom_s3 [0:2];
	logic          dneg_s3 [0:2];

	function automatic logic [CW-1:0] mag_c(input logic signed [CW-1:0] x);
		return x[CW-1] ? CW'(-x) : CW'(x);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dd_s3[k]   <= PW'(mag_c(d_s2[k])) * PW'(mag_c(d_s2[k]));
				oo_s3[k]   <= PW'(mag_c(o_s2[k])) * PW'(mag_c(o_s2[k]));
				dom_s3[k]  <= PW'(mag_c(d_s2[k])) * PW'(mag_c(o_s2[k]));
				dneg_s3[k] <= d_s2[k][CW-1] != o_s2[k][CW-1];
			end
		end
	end

	// Stage 4: a, h, c
	logic [PW-1:0] a_s4, hmag_s4, cmag_s4;
	logic          hneg_s4, cneg_s4;
	localparam logic [PW-1:0] ONE2 = PW'(1) << (2 * FRAC_BITS);
	logic [PW-1:0] a_c, hp_c, hn_c, s2_c;

	always_comb begin
		a_c = dd_s3[0] + dd_s3[1] + dd_s3[2];
		s2_c = oo_s3[0] + oo_s3[1] + oo_s3[2];
		hp_c = '0;
		hn_c = '0;
		for (int k = 0; k < 3; k++) begin
			if (dneg_s3[k]) begin
				hn_c = hn_c + dom_s3[k];
			end else begin
				hp_c = hp_c + dom_s3[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4    <= a_c;
			hneg_s4 <= hn_c > hp_c;
			hmag_s4 <= (hn_c > hp_c) ? hn_c - hp_c : hp_c - hn_c;
			cneg_s4 <= s2_c < ONE2;
			cmag_s4 <= (s2_c < ONE2) ? ONE2 - s2_c : s2_c - ONE2;
		end
	end

	// Stage 5: h*h and a*c split into 32 bit partial products
	localparam int HW = PW / 2;
	logic [PW-1:0] hh_pp_s5 [0:3];
	logic [PW-1:0] ac_pp_s5 [0:3];
	logic [PW-1:0] a_s5, hmag_s5;
	logic          hneg_s5, cneg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4 && a_s4 != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hh_pp_s5[0] <= PW'(hmag_s4[HW-1:0]) * PW'(hmag_s4[HW-1:0]);
			hh_pp_s5[1] <= PW'(hmag_s4[HW-1:0]) * PW'(hmag_s4[PW-1:HW]);
			hh_pp_s5[2] <= PW'(hmag_s4[PW-1:HW]) * PW'(hmag_s4[HW-1:0]);
			hh_pp_s5[3] <= PW'(hmag_s4[PW-1:HW]) * PW'(hmag_s4[PW-1:HW]);
			ac_pp_s5[0] <= PW'(a_s4[HW-1:0]) * PW'(cmag_s4[HW-1:0]);
			ac_pp_s5[1] <= PW'(a_s4[HW-1:0]) * PW'(cmag_s4[PW-1:HW]);
			ac_pp_s5[2] <= PW'(a_s4[PW-1:HW]) * PW'(cmag_s4[HW-1:0]);
			ac_pp_s5[3] <= PW'(a_s4[PW-1:HW]) * PW'(cmag_s4[PW-1:HW]);
			a_s5    <= a_s4;
			hmag_s5 <= hmag_s4;
			hneg_s5 <= hneg_s4;
			cneg_s5 <= cneg_s4;
		end
	end

	// Stage 6: assemble h^2 and a*c
	logic v_s6;
	logic [NW-1:0] h2_s6, ac_s6;
	logic [PW-1:0] a_s6, hmag_s6;
	logic          hneg_s6, cneg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h2_s6 <= NW'(hh_pp_s5[0]) + (NW'(hh_pp_s5[1]) << HW)
				+ (NW'(hh_pp_s5[2]) << HW) + (NW'(hh_pp_s5[3]) << PW);
			ac_s6 <= NW'(ac_pp_s5[0]) + (NW'(ac_pp_s5[1]) << HW)
				+ (NW'(ac_pp_s5[2]) << HW) + (NW'(ac_pp_s5[3]) << PW);
			a_s6    <= a_s5;
			hmag_s6 <= hmag_s5;
			hneg_s6 <= hneg_s5;
			cneg_s6 <= cneg_s5;
		end
	end

	// Stage 7: discriminant, drop misses
	logic v_s7;
	logic [NW-1:0] disc_s7;
	logic [PW-1:0] a_s7, hmag_s7;
	logic          hneg_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6 && (cneg_s6 || h2_s6 >= ac_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			disc_s7 <= cneg_s6 ? h2_s6 + ac_s6 : h2_s6 - ac_s6;
			a_s7    <= a_s6;
			hmag_s7 <= hmag_s6;
			hneg_s7 <= hneg_s6;
		end
	end

	// Square root; side data rides along as a tag
	localparam int T1 = 1 + 1 + 2 * PW;
	logic [T1-1:0] sq_tag_out;
	logic [PW-1:0] root_s8;

	rsi_isqrt #(.RW(PW), .TW(T1)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.radicand(disc_s7),
		.tag_in({v_s7, hneg_s7, hmag_s7, a_s7}),
		.root(root_s8),
		.tag_out(sq_tag_out)
	);

	logic          v_s8, hneg_s8;
	logic [PW-1:0] hmag_s8, a_s8;
	assign {v_s8, hneg_s8, hmag_s8, a_s8} = sq_tag_out;

	// Stage 9: signed-magnitude numerators -h-s and -h+s
	logic v_s9, nneg_s9, fneg_s9;
	logic [PW:0]   nnum_s9, fnum_s9;
	logic [PW-1:0] a_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s9 <= a_s8;
			// -h is positive when h is negative
			if (hneg_s8) begin
				fneg_s9 <= 1'b0;
				fnum_s9 <= (PW+1)'(hmag_s8) + (PW+1)'(root_s8);
				if (hmag_s8 < root_s8) begin
					nneg_s9 <= 1'b1;
					nnum_s9 <= (PW+1)'(root_s8 - hmag_s8);
				end else begin
					nneg_s9 <= 1'b0;
					nnum_s9 <= (PW+1)'(hmag_s8 - root_s8);
				end
			end else begin
				nneg_s9 <= 1'b1;
				nnum_s9 <= (PW+1)'(hmag_s8) + (PW+1)'(root_s8);
				if (hmag_s8 < root_s8) begin
					fneg_s9 <= 1'b0;
					fnum_s9 <= (PW+1)'(root_s8 - hmag_s8);
				end else begin
					fneg_s9 <= 1'b1;
					fnum_s9 <= (PW+1)'(hmag_s8 - root_s8);
				end
			end
		end
	end

	// Two dividers, one for each hit
	localparam int DNW = PW + 1 + FRAC_BITS;
	logic [DNW-1:0] nq, fq;
	logic [2:0]     dtag_n, dtag_f;

	rsi_div #(.NW(DNW), .DW(PW), .TW(3)) u_div_near (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num({nnum_s9, FRAC_BITS'(0)}), .den(a_s9),
		.tag_in({v_s9, nneg_s9, fneg_s9}),
		.quo(nq), .tag_out(dtag_n)
	);

	rsi_div #(.NW(DNW), .DW(PW), .TW(1)) u_div_far (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num({fnum_s9, FRAC_BITS'(0)}), .den(a_s9),
		.tag_in(1'b0),
		.quo(fq), .tag_out()
	);

	// Saturate and sign
	localparam logic [DNW-1:0] LIMQ = DNW'(1) << (CW - 1);

	function automatic logic [CW-1:0] hit_dist(input logic neg, input logic [DNW-1:0] q);
		logic [DNW-1:0] mx;
		logic [DNW-1:0] m;
		mx = neg ? LIMQ : LIMQ - DNW'(1);
		m = (q > mx) ? mx : q;
		return neg ? CW'(-m) : CW'(m);
	endfunction

	assign out_v = dtag_n[2];

	// Skid buffer of four items
	logic [CW:0] buf_q [0:DEPTH-1];
	logic [1:0]  wp_q, rp_q;
	logic        pop;

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = fifo_cnt_q != '0;
	assign m_axis_tdata  = buf_q[rp_q][CW-1:0];
	assign m_axis_tlast  = buf_q[rp_q][CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (en && out_v) begin
				wp_q <= wp_q + 2'd2;
			end
			if (pop) begin
				rp_q <= rp_q + 2'd1;
			end
			fifo_cnt_q <= fifo_cnt_q + ((en && out_v) ? 3'd2 : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en && out_v) begin
			buf_q[wp_q]         <= {1'b0, hit_dist(dtag_n[1], nq)};
			buf_q[wp_q + 2'd1]  <= {1'b1, hit_dist(dtag_n[0], fq)};
		end
	end
endmodule

>>> hdl/rsi_isqrt.sv
// Pipelined restoring square root, one result bit per stage
module rsi_isqrt #(
	parameter int RW = 64,
	parameter int TW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [2*RW-1:0]     radicand,
	input  logic [TW-1:0]       tag_in,
	output logic [RW-1:0]       root,
	output logic [TW-1:0]       tag_out
);
	logic [2*RW-1:0] rem_s [0:RW];
	logic [RW-1:0]   res_s [0:RW];
	logic [TW-1:0]   tag_s [0:RW];

	always_comb begin
		rem_s[0] = radicand;
		res_s[0] = '0;
		tag_s[0] = tag_in;
	end

	for (genvar g = 0; g < RW; g++) begin : g_bit
		localparam int B = RW - 1 - g;
		logic [2*RW+1:0] trial;
		logic [2*RW+1:0] rem_ext;
		logic [RW-1:0]   cand;
		always_comb begin
			cand    = res_s[g] | (RW'(1) << B);
			trial   = ((2*RW+2)'(res_s[g]) << (B + 1)) | ((2*RW+2)'(1) << (2 * B));
			rem_ext = (2*RW+2)'(rem_s[g]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[g+1] <= '0;
			end else if (en) begin
				tag_s[g+1] <= tag_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_ext >= trial) begin
					rem_s[g+1] <= rem_s[g] - (2*RW)'(trial);
					res_s[g+1] <= cand;
				end else begin
					rem_s[g+1] <= rem_s[g];
					res_s[g+1] <= res_s[g];
				end
			end
		end
	end

	assign root    = res_s[RW];
	assign tag_out = tag_s[RW];
endmodule

>>> hdl/rsi_div.sv
// Pipelined restoring divider of a wide numerator by a 64 bit divisor
module rsi_div #(
	parameter int NW = 96,
	parameter int DW = 64,
	parameter int TW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [NW-1:0]  num,
	input  logic [DW-1:0]  den,
	input  logic [TW-1:0]  tag_in,
	output logic [NW-1:0]  quo,
	output logic [TW-1:0]  tag_out
);
	logic [NW-1:0] n_s [0:NW];
	logic [DW:0]   r_s [0:NW];
	logic [DW-1:0] d_s [0:NW];
	logic [TW-1:0] t_s [0:NW];

	always_comb begin
		n_s[0] = num;
		r_s[0] = '0;
		d_s[0] = den;
		t_s[0] = tag_in;
	end

	for (genvar g = 0; g < NW; g++) begin : g_bit
		logic [DW:0] sh;
		always_comb sh = {r_s[g][DW-1:0], n_s[g][NW-1]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				t_s[g+1] <= '0;
			end else if (en) begin
				t_s[g+1] <= t_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[g+1] <= d_s[g];
				if (sh >= {1'b0, d_s[g]}) begin
					r_s[g+1] <= sh - {1'b0, d_s[g]};
					n_s[g+1] <= {n_s[g][NW-2:0], 1'b1};
				end else begin
					r_s[g+1] <= sh;
					n_s[g+1] <= {n_s[g][NW-2:0], 1'b0};
				end
			end
		end
	end

	assign quo     = n_s[NW];
	assign tag_out = t_s[NW];
endmodule

>>> sim/tb.sv
// Self-checking testbench for the ray and unit sphere intersection block
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rsi_pkg::*;

	typedef enum int {MAT_MILD, MAT_FULL, MAT_CORNER, MAT_ZERO, MAT_IDENTITY} mat_kind_t;

	typedef struct {
		logic [31:0] t_hit;
		logic        last;
	} hit_t;

	typedef struct {
		logic [191:0] ray;
		bit           typed;
		int           n;
		logic [31:0]  e0;
		logic [31:0]  e1;
	} ray_row_t;

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] TWO = 32'h0002_0000;
	localparam logic [31:0] NTWO = 32'hFFFE_0000;
	localparam logic [31:0] FIVE = 32'h0005_0000;
	localparam int NUM_ROWS = 14;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	logic [191:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// hit_distance
	logic [31:0] m_axis_tdata;
	logic m_axis_tlast;

	logic [63:0] mat_regs [NUM_REGS];
	hit_t hit_q [$];
	ray_row_t rows [NUM_ROWS];
	int errors = 0;
	int rays_sent = 0;
	int hits_checked = 0;
	int settings_used = 1;
	int snd_idle_pct = 9;
	int rcv_idle_pct = 52;
	int rcv_hold = 0;

	ray_sphere_intersect dut (.*);

	always #4 clk = ~clk;

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("tb: mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint mat_entry(input int row, input int col);
		logic [63:0] r;
		r = mat_regs[row * 2 + col / 2];
		return (col % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
	endfunction

	function automatic longint sat_coord(input longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483647)
			return -64'sd2147483647;
		return x;
	endfunction

	function automatic logic [127:0] signed_sum(input bit na, input logic [127:0] x,
			input bit nb, input logic [127:0] y, output bit nr);
		if (na == nb) begin
			nr = na;
			return x + y;
		end
		if (x < y) begin
			nr = nb;
			return y - x;
		end
		nr = na;
		return x - y;
	endfunction

	function automatic logic [31:0] hit_param(input bit neg, input logic [127:0] num,
			input logic [63:0] a);
		logic [127:0] q;
		logic [63:0] maxmag, r;
		q = (num << 16) / {64'd0, a};
		maxmag = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (q[127:64] != 0 || q[63:0] > maxmag)
			q = {64'd0, maxmag};
		r = neg ? -q[63:0] : q[63:0];
		return r[31:0];
	endfunction

	function automatic int predict_hits(input logic [191:0] ray,
			output logic [31:0] t_near, output logic [31:0] t_far);
		longint v [6];
		longint o [3];
		longint d [3];
		longint acc_o, acc_d, m;
		logic [63:0] a, s2, hp, hn, hmag, cmag, md, mo, root, cand;
		logic [127:0] h2, ac, disc, nnum, fnum;
		bit hneg, cneg, nneg, fneg;
		t_near = '0;
		t_far = '0;
		for (int i = 0; i < 6; i++)
			v[i] = longint'($signed(ray[32*i +: 32]));
		for (int i = 0; i < 3; i++) begin
			acc_o = mat_entry(i, 3);
			acc_d = 0;
			for (int j = 0; j < 3; j++) begin
				m = mat_entry(i, j);
				acc_o += (m * v[j]) >>> 16;
				acc_d += (m * v[3 + j]) >>> 16;
			end
			o[i] = sat_coord(acc_o);
			d[i] = sat_coord(acc_d);
		end
		a = 0;
		s2 = 0;
		hp = 0;
		hn = 0;
		for (int i = 0; i < 3; i++) begin
			md = d[i] < 0 ? -d[i] : d[i];
			mo = o[i] < 0 ? -o[i] : o[i];
			a += md * md;
			s2 += mo * mo;
			if ((d[i] < 0) != (o[i] < 0))
				hn += md * mo;
			else
				hp += md * mo;
		end
		if (a == 0)
			return 0;
		hneg = hn > hp;
		hmag = hneg ? hn - hp : hp - hn;
		cneg = s2 < 64'h1_0000_0000;
		cmag = cneg ? 64'h1_0000_0000 - s2 : s2 - 64'h1_0000_0000;
		h2 = {64'd0, hmag} * {64'd0, hmag};
		ac = {64'd0, a} * {64'd0, cmag};
		if (cneg) begin
			disc = h2 + ac;
		end else begin
			if (h2 < ac)
				return 0;
			disc = h2 - ac;
		end
		root = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (!(disc < {64'd0, cand} * {64'd0, cand}))
				root = cand;
		end
		nnum = signed_sum(!hneg, {64'd0, hmag}, 1'b1, {64'd0, root}, nneg);
		fnum = signed_sum(!hneg, {64'd0, hmag}, 1'b0, {64'd0, root}, fneg);
		t_near = hit_param(nneg, nnum, a);
		t_far = hit_param(fneg, fnum, a);
		return 2;
	endfunction

	function automatic logic [191:0] mk_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
		return {dz, dy, dx, oz, oy, ox};
	endfunction

	task automatic push_hits(input int n, input logic [31:0] t0, input logic [31:0] t1);
		if (n == 2) begin
			hit_q.push_back('{t_hit: t0, last: 1'b0});
			hit_q.push_back('{t_hit: t1, last: 1'b1});
		end
	endtask

	task automatic send_ray(input logic [191:0] ray, input bit typed, input int n,
			input logic [31:0] e0, input logic [31:0] e1);
		logic [31:0] t0, t1;
		int cnt;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ray;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (typed) begin
			push_hits(n, e0, e1);
		end else begin
			cnt = predict_hits(ray, t0, t1);
			push_hits(cnt, t0, t1);
		end
		rays_sent++;
		if ($urandom_range(99) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		if (s_axis_tvalid) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		while (hit_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 6'(int'(idx) * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		mat_regs[idx] = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value)
			report_mismatch("register readback", prdata, value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_signed(input int span);
		return 32'($urandom_range(2 * span)) - 32'(span);
	endfunction

	task automatic load_matrix(input mat_kind_t kind);
		logic [31:0] e [4][4];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				case (kind)
					MAT_MILD: begin
						if (r == c)
							e[r][c] = 32'($urandom_range(32'h8000, 32'h2_0000));
						else if (c == 3)
							e[r][c] = rand_signed(32'h2_0000);
						else
							e[r][c] = rand_signed(32'h4000);
					end
					MAT_FULL: e[r][c] = $urandom();
					MAT_CORNER: e[r][c] = ((r + c) % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
					MAT_ZERO: e[r][c] = (c == 3) ? $urandom() : 32'h0;
					default: e[r][c] = (r == c) ? ONE : 32'h0;
				endcase
		for (int r = 0; r < 4; r++)
			for (int k = 0; k < 2; k++)
				write_reg(reg_idx_t'(r * 2 + k), {e[r][2*k+1], e[r][2*k]});
		settings_used++;
	endtask

	task automatic random_rays(input int count);
		logic [31:0] o [3];
		logic [31:0] d [3];
		int sel, sh;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(99);
			sh = $urandom_range(6);
			for (int i = 0; i < 3; i++) begin
				o[i] = rand_signed(32'h4_0000);
				d[i] = $signed(rand_signed(32'h1_0000) - o[i]) >>> sh;
			end
			if (sel < 25) begin
				for (int i = 0; i < 3; i++) begin
					o[i] = $urandom();
					d[i] = $urandom();
				end
			end else if (sel < 32) begin
				for (int i = 0; i < 3; i++)
					d[i] = 32'h0;
			end
			if (rays_sent == 400)
				rcv_hold = 3000;
			if (rays_sent == 1000)
				drain();
			if (rays_sent == 800) begin
				snd_idle_pct = 52;
				rcv_idle_pct = 9;
			end else if (rays_sent == 1500) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			send_ray(mk_ray(o[0], o[1], o[2], d[0], d[1], d[2]), 1'b0, 0, '0, '0);
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_REGS; i++)
			mat_regs[i] = 64'd0;
		mat_regs[REG_M00_M01] = RESET_DIAG_LO;
		mat_regs[REG_M10_M11] = RESET_DIAG_HI;
		mat_regs[REG_M22_M23] = RESET_DIAG_LO;
		mat_regs[REG_M32_M33] = RESET_DIAG_HI;
		rows[0] = '{mk_ray(0, 0, NTWO, 0, 0, ONE), 1, 2, ONE, 32'h0003_0000};
		rows[1] = '{mk_ray(0, 0, NTWO, 0, 0, 0), 1, 0, '0, '0};
		rows[2] = '{mk_ray(0, FIVE, NTWO, 0, 0, ONE), 1, 0, '0, '0};
		rows[3] = '{mk_ray(ONE, 0, NTWO, 0, 0, ONE), 1, 2, TWO, TWO};
		rows[4] = '{mk_ray(0, 0, 0, ONE, 0, 0), 1, 2, 32'hFFFF_0000, ONE};
		rows[5] = '{mk_ray(NTWO, 0, 0, 32'd1, 0, 0), 1, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		rows[6] = '{mk_ray(TWO, 0, 0, 32'd1, 0, 0), 1, 2, 32'h8000_0000, 32'h8000_0000};
		rows[7] = '{{6{32'h7FFF_FFFF}}, 0, 0, '0, '0};
		rows[8] = '{{6{32'h8000_0000}}, 0, 0, '0, '0};
		rows[9] = '{{{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}}, 0, 0, '0, '0};
		rows[10] = '{{6{32'hFFFF_FFFF}}, 0, 0, '0, '0};
		rows[11] = '{{3{64'h5555_5555_AAAA_AAAA}}, 0, 0, '0, '0};
		rows[12] = '{{3{64'hAAAA_AAAA_5555_5555}}, 0, 0, '0, '0};
		rows[13] = '{mk_ray(32'h8000, 32'hFFFF_8000, 0, 32'd3, 32'hFFFF_FFFD, 32'd7),
			0, 0, '0, '0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int i = 0; i < NUM_ROWS; i++)
			send_ray(rows[i].ray, rows[i].typed, rows[i].n, rows[i].e0, rows[i].e1);
		random_rays(300);
		drain();
		load_matrix(MAT_MILD);
		random_rays(500);
		drain();
		load_matrix(MAT_FULL);
		random_rays(250);
		drain();
		load_matrix(MAT_CORNER);
		random_rays(250);
		drain();
		load_matrix(MAT_ZERO);
		random_rays(40);
		drain();
		load_matrix(MAT_MILD);
		random_rays(500);
		drain();
		load_matrix(MAT_IDENTITY);
		random_rays(200);
		drain();
		$display("tb: %0d rays over %0d matrix settings, %0d hit distances checked",
			rays_sent, settings_used, hits_checked);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		hit_t want;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (hit_q.size() == 0) begin
					report_mismatch("unexpected item", {32'd0, m_axis_tdata}, 64'd0);
				end else begin
					want = hit_q.pop_front();
					hits_checked++;
					if (m_axis_tdata !== want.t_hit)
						report_mismatch("hit_distance", m_axis_tdata, want.t_hit);
					if (m_axis_tlast !== want.last)
						report_mismatch("tlast", m_axis_tlast, want.last);
				end
			end
			if (rcv_hold > 0) begin
				rcv_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end
endmodule
